// ===== rtl/core/ssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, codes and widths shared by the spectral subtraction denoise unit.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int FFT_SIZE_DEF   = 1024;
	localparam int MAX_FRAMES_DEF = 255;

	localparam int IDX_W   = 10;
	localparam int PART_W  = 24;
	localparam int SUM_W   = 32;
	localparam int COEF_W  = 16;
	localparam int SQR_W   = 2 * PART_W;
	localparam int FRAC_W  = 12;
	localparam int SCL_W   = SUM_W + COEF_W - FRAC_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] OP_CAPTURE = 2'd0;
	localparam logic [1:0] OP_APPLY   = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 1'd1;

	localparam logic [COEF_W-1:0] STRENGTH_RST = 16'd4096;
	localparam logic [COEF_W-1:0] FLOOR_RST    = 16'd0;

	typedef struct packed {
		logic [1:0]               opcode;
		logic [IDX_W-1:0]         bin_index;
		logic signed [PART_W-1:0] bin_real;
		logic signed [PART_W-1:0] bin_imag;
		logic                     frame_end;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [PART_W-1:0] out_real;
		logic signed [PART_W-1:0] out_imag;
	} out_word_t;

endpackage

// ===== rtl/core/ssd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 513
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/ssd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_sqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module ssd_sqrt
	import ssd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQR_W-1:0]  radicand,
	output logic              done,
	output logic [PART_W-1:0] root
);

	localparam int STEPS = SQR_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam int REM_W = PART_W + 2;

	logic [SQR_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [PART_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign rem_sh = {rem_q[PART_W-1:0], rad_q[SQR_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SQR_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[PART_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

`ifndef SYNTHESIS
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("sqrt done held longer than one cycle");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("sqrt restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("sqrt done without a run");
`endif

endmodule

// ===== rtl/core/ssd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssd_div
	import ssd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQR_W-1:0]  dividend,
	input  logic [PART_W-1:0] divisor,
	output logic              done,
	output logic [SQR_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(SQR_W + 1);

	logic [SQR_W-1:0]  dvd_q;
	logic [PART_W-1:0] dvs_q;
	logic [PART_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PART_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[SQR_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? PART_W'(trial - {1'b0, dvs_q}) : trial[PART_W-1:0];
			dvd_q <= {dvd_q[SQR_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

`ifndef SYNTHESIS
	a_done_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divide done held longer than one cycle");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");
	a_nonzero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> dvs_q != '0)
		else $error("divide by zero");
`endif

endmodule

// ===== rtl/core/spectral_subtraction_denoise_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_subtraction_denoise_unit
// Per-bin spectral subtraction with a captured noise profile in RAM.
// ----------------------------------------------------------------------------
// One word is processed at a time. Clear and unused opcodes return straight
// to idle, as does a capture once the frame count is full. Other captures
// run the 24-step iterative square root, then a RAM read-modify-write. An
// apply also runs the square root; an apply against a profile adds a noise
// divide and, when the bin is scaled, two more divides. All dividing runs
// through one shared bit-serial divider. The noise sums live in one RAM of
// FFT_SIZE/2+1 entries (capped at 1024) that needs no clearing.
// ----------------------------------------------------------------------------
module spectral_subtraction_denoise_unit
	import ssd_pkg::*;
#(
	parameter int FFT_SIZE   = FFT_SIZE_DEF,
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  in_word_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output out_word_t            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	localparam int NBINS = FFT_SIZE / 2 + 1;
	localparam int DEPTH = (NBINS > (1 << IDX_W)) ? (1 << IDX_W) : NBINS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_FRAMES + 1);
	localparam int NM_W  = SCL_W + 2;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SQRT  = 4'd1;
	localparam logic [3:0] S_WR    = 4'd2;
	localparam logic [3:0] S_NGO   = 4'd3;
	localparam logic [3:0] S_NWAIT = 4'd4;
	localparam logic [3:0] S_MUL   = 4'd5;
	localparam logic [3:0] S_DEC   = 4'd6;
	localparam logic [3:0] S_PRD   = 4'd7;
	localparam logic [3:0] S_RGO   = 4'd8;
	localparam logic [3:0] S_RWAIT = 4'd9;
	localparam logic [3:0] S_IGO   = 4'd10;
	localparam logic [3:0] S_IWAIT = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [3:0]         state_q;
	logic [COEF_W-1:0]  strength_q;
	logic [COEF_W-1:0]  floor_q;
	logic [CW-1:0]      count_q;
	logic [1:0]         op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [PART_W-1:0]  re_q;
	logic [PART_W-1:0]  im_q;
	logic               last_q;
	logic               inrange_q;
	logic [PART_W-1:0]  mag_q;
	logic [SUM_W-1:0]   noise_q;
	logic [SCL_W-1:0]   sub_q;
	logic [SCL_W-1:0]   flr_q;
	logic [PART_W-1:0]  nm_q;
	logic [SQR_W-1:0]   pr_re_q;
	logic [SQR_W-1:0]   pr_im_q;
	logic [PART_W-1:0]  res_re_q;
	logic [PART_W-1:0]  res_im_q;
	logic               rsp_valid_q;
	out_word_t          rsp_q;

	logic               req_acc;
	logic               cap_ok;
	logic               req_inrange;
	logic signed [SQR_W-1:0] sq_re;
	logic signed [SQR_W-1:0] sq_im;
	logic [SQR_W-1:0]   radicand;
	logic               sq_start;
	logic               sq_done;
	logic [PART_W-1:0]  sq_root;
	logic               div_start;
	logic [SQR_W-1:0]   div_dvd;
	logic [PART_W-1:0]  div_dvs;
	logic               div_done;
	logic [SQR_W-1:0]   div_q;
	logic [SUM_W-1:0]   ram_rdata;
	logic [SUM_W-1:0]   ram_wdata;
	logic               ram_we;
	logic [SUM_W:0]     sum_ext;
	logic [SQR_W-1:0]   sub_prod;
	logic [SQR_W-1:0]   flr_prod;
	logic signed [NM_W-1:0] nm_diff;
	logic signed [NM_W-1:0] nm;
	logic [PART_W-1:0]  abs_re;
	logic [PART_W-1:0]  abs_im;
	logic [PART_W-1:0]  qpart;
	logic               out_free;

	assign req_stall   = state_q != S_IDLE;
	assign req_acc     = req_valid && !req_stall;
	assign cap_ok      = count_q < CW'(MAX_FRAMES);
	assign req_inrange = 32'(req.bin_index) < 32'(NBINS);

	assign sq_re    = req.bin_real * req.bin_real;
	assign sq_im    = req.bin_imag * req.bin_imag;
	assign radicand = sq_re + sq_im;
	assign sq_start = req_acc && ((req.opcode == OP_CAPTURE && cap_ok) ||
		req.opcode == OP_APPLY);

	ssd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (sq_root)
	);

	assign div_start = state_q == S_NGO || state_q == S_RGO || state_q == S_IGO;

	always_comb begin
		div_dvd = pr_im_q;
		div_dvs = mag_q;
		unique case (state_q)
			S_NGO: begin
				div_dvd = SQR_W'(ram_rdata);
				div_dvs = PART_W'(count_q);
			end
			S_RGO:   div_dvd = pr_re_q;
			default: div_dvd = pr_im_q;
		endcase
	end

	ssd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	// first frame overwrites; later frames saturate at all ones
	assign sum_ext   = {1'b0, ram_rdata} + (SUM_W + 1)'(mag_q);
	assign ram_wdata = (count_q == '0) ? SUM_W'(mag_q) :
		(sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0]);
	assign ram_we    = state_q == S_WR && inrange_q;

	ssd_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (ram_wdata),
		.re    (req_acc),
		.raddr (req.bin_index[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign sub_prod = SQR_W'(strength_q * noise_q);
	assign flr_prod = SQR_W'(floor_q * noise_q);
	assign nm_diff  = $signed(NM_W'(mag_q)) - $signed(NM_W'(sub_q));
	assign nm       = (nm_diff < $signed(NM_W'(flr_q))) ? $signed(NM_W'(flr_q)) : nm_diff;
	assign abs_re   = re_q[PART_W-1] ? PART_W'(-re_q) : re_q;
	assign abs_im   = im_q[PART_W-1] ? PART_W'(-im_q) : im_q;
	assign qpart    = div_q[PART_W-1:0];
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= STRENGTH_RST;
			floor_q    <= FLOOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRENGTH: strength_q <= cfg_data;
				REG_FLOOR:    floor_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop the taken word unless a new one replaces it below
			if (rsp_valid_q && !rsp_stall && state_q != S_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.opcode == OP_CLEAR) begin
							count_q <= '0;
						end
						if (sq_start) begin
							state_q <= S_SQRT;
						end
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						if (op_q == OP_CAPTURE) begin
							state_q <= S_WR;
						end else if (inrange_q && count_q != '0) begin
							state_q <= S_NGO;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_WR: begin
					if (last_q) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_NGO:   state_q <= S_NWAIT;
				S_NWAIT: if (div_done) state_q <= S_MUL;
				S_MUL:   state_q <= S_DEC;
				S_DEC: begin
					if (mag_q != '0 && nm > 0 && nm < $signed(NM_W'(mag_q))) begin
						state_q <= S_PRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_PRD:   state_q <= S_RGO;
				S_RGO:   state_q <= S_RWAIT;
				S_RWAIT: if (div_done) state_q <= S_IGO;
				S_IGO:   state_q <= S_IWAIT;
				S_IWAIT: if (div_done) state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q      <= req.opcode;
			idx_q     <= req.bin_index;
			re_q      <= req.bin_real;
			im_q      <= req.bin_imag;
			last_q    <= req.frame_end;
			inrange_q <= req_inrange;
		end
		if (state_q == S_SQRT && sq_done) begin
			mag_q    <= sq_root;
			res_re_q <= re_q;
			res_im_q <= im_q;
		end
		if (state_q == S_NWAIT && div_done) begin
			noise_q <= div_q[SUM_W-1:0];
		end
		if (state_q == S_MUL) begin
			sub_q <= sub_prod[SQR_W-1:FRAC_W];
			flr_q <= flr_prod[SQR_W-1:FRAC_W];
		end
		if (state_q == S_DEC) begin
			nm_q <= nm[PART_W-1:0];
			if (mag_q == '0) begin
				res_re_q <= (nm > $signed(NM_W'(24'h7FFFFF))) ? 24'h7FFFFF : nm[PART_W-1:0];
				res_im_q <= '0;
			end else if (nm <= 0) begin
				res_re_q <= '0;
				res_im_q <= '0;
			end
		end
		if (state_q == S_PRD) begin
			pr_re_q <= abs_re * nm_q;
			pr_im_q <= abs_im * nm_q;
		end
		if (state_q == S_RWAIT && div_done) begin
			res_re_q <= re_q[PART_W-1] ? PART_W'(-qpart) : qpart;
		end
		if (state_q == S_IWAIT && div_done) begin
			res_im_q <= im_q[PART_W-1] ? PART_W'(-qpart) : qpart;
		end
		if (state_q == S_OUT && out_free) begin
			rsp_q.out_index <= idx_q;
			rsp_q.out_real  <= res_re_q;
			rsp_q.out_imag  <= res_im_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAMES))
		else $error("frame count beyond limit");
	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.opcode == OP_CLEAR) |=> count_q == '0)
		else $error("clear did not reset the frame count");
	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RGO || state_q == S_IGO) |-> mag_q != '0)
		else $error("bin scaling with zero magnitude");
	a_out_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> op_q == OP_APPLY)
		else $error("result raised by a non-apply word");
`endif

endmodule

// ===== test/spectral_subtraction_denoise_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_subtraction_denoise_unit_test
// Self-checking bench for the spectral subtraction denoise unit. Noise frames
// are captured into a few bins and applies are checked against an in-bench
// predictor of the gain math. Strength and floor are swept across several
// settings, and the frame count is driven to saturation. Both handshakes see
// random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
module spectral_subtraction_denoise_unit_test;
	import ssd_pkg::*;

	localparam int NBINS       = FFT_SIZE_DEF / 2 + 1;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_WAIT  = 250;
	localparam logic [1:0] OP_NONE = 2'd3;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	in_word_t       req;
	logic           rsp_valid;
	logic           rsp_stall;
	out_word_t      rsp;
	logic           cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	// bins that captures and applies use; all are written by the first frame
	int unsigned    used_bins[7] = '{0, 1, 2, 3, 255, 511, 512};

	in_word_t       pending_words[$];
	out_word_t      expected_bins[$];
	logic [31:0]    noise_sum[NBINS];
	int unsigned    frame_count;
	logic [15:0]    strength;
	logic [15:0]    floor_gain;
	int unsigned    mismatches;
	int unsigned    applies_checked;
	int unsigned    cycles;
	int unsigned    burst_left;
	int unsigned    gap_left;
	int unsigned    stall_mode;
	int unsigned    stall_tick;

	spectral_subtraction_denoise_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint scale_by(longint x, longint unsigned num,
			longint unsigned den);
		longint unsigned a;
		longint unsigned q;
		a = (x < 0) ? longint'(-x) : longint'(x);
		q = (a * num) / den;
		return (x < 0) ? -longint'(q) : longint'(q);
	endfunction

	// update the noise profile and queue the expected bin for one accepted word
	function automatic void predict_bin(in_word_t w);
		longint re;
		longint im;
		longint unsigned mag;
		longint unsigned noise;
		longint unsigned s;
		longint sub;
		longint flr;
		longint nm;
		longint ore;
		longint oim;
		bit in_range;
		out_word_t o;
		re = longint'(w.bin_real);
		im = longint'(w.bin_imag);
		mag = int_sqrt(longint'(re * re) + longint'(im * im));
		in_range = w.bin_index < NBINS;
		if (w.opcode == OP_CLEAR) begin
			frame_count = 0;
		end else if (w.opcode == OP_CAPTURE) begin
			if (frame_count < MAX_FRAMES_DEF) begin
				if (in_range) begin
					if (frame_count == 0) begin
						noise_sum[w.bin_index] = mag[31:0];
					end else begin
						s = longint'(noise_sum[w.bin_index]) + mag;
						noise_sum[w.bin_index] = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
					end
				end
				if (w.frame_end)
					frame_count++;
			end
		end else if (w.opcode == OP_APPLY) begin
			ore = re;
			oim = im;
			if (in_range && frame_count != 0) begin
				noise = longint'(noise_sum[w.bin_index]) / frame_count;
				sub = longint'((longint'(strength) * noise) >> 12);
				flr = longint'((longint'(floor_gain) * noise) >> 12);
				nm = longint'(mag) - sub;
				if (nm < flr)
					nm = flr;
				if (mag == 0) begin
					ore = (nm > 8388607) ? 8388607 : nm;
					oim = 0;
				end else if (nm <= 0) begin
					ore = 0;
					oim = 0;
				end else if (longint'(nm) < longint'(mag)) begin
					ore = scale_by(re, nm, mag);
					oim = scale_by(im, nm, mag);
				end
			end
			o.out_index = w.bin_index;
			o.out_real = ore[23:0];
			o.out_imag = oim[23:0];
			expected_bins.push_back(o);
		end
	endfunction

	function automatic logic [23:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'(int'($urandom_range(0, 2000)) - 1000);
			3: return 24'(int'($urandom_range(0, 200000)) - 100000);
			4: return 24'd0;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic queue_word(logic [1:0] op, int unsigned idx, logic [23:0] re,
			logic [23:0] im, bit last);
		in_word_t w;
		w.opcode = op;
		w.bin_index = idx[9:0];
		w.bin_real = re;
		w.bin_imag = im;
		w.frame_end = last;
		pending_words.push_back(w);
	endtask

	function automatic int unsigned pick_bin();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(NBINS, 1023);
		return used_bins[$urandom_range(0, 6)];
	endfunction

	// captures of a random subset of bins, closed by a frame end
	task automatic queue_frame();
		int unsigned n;
		n = $urandom_range(1, 7);
		for (int i = 0; i < n; i++)
			queue_word(OP_CAPTURE, pick_bin(), rand_part(), rand_part(), i == n - 1);
	endtask

	task automatic queue_random(int unsigned count);
		int unsigned r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				queue_frame();
			else if (r < 80)
				queue_word(OP_APPLY, pick_bin(), rand_part(), rand_part(),
					1'($urandom_range(0, 1)));
			else if (r < 86)
				queue_word(OP_CLEAR, pick_bin(), rand_part(), rand_part(),
					1'($urandom_range(0, 1)));
			else if (r < 92)
				queue_word(OP_NONE, $urandom_range(0, 1023), rand_part(), rand_part(),
					1'($urandom_range(0, 1)));
			else
				queue_word(OP_CAPTURE, pick_bin(), rand_part(), rand_part(),
					1'($urandom_range(0, 1)));
		end
	endtask

	task automatic wait_idle();
		while (pending_words.size() != 0 || expected_bins.size() != 0 || req_valid)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == REG_STRENGTH)
			strength = value;
		else
			floor_gain = value;
	endtask

	// sender: bursts of random length, random gaps; predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				predict_bin(req);
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				req <= pending_words.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches to a random mode each time stall_tick[5:0] wraps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode <= 0;
			stall_tick <= 0;
		end else begin
			stall_tick <= stall_tick + 1;
			if (stall_tick[5:0] == 6'd63)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= 1'($urandom_range(0, 1));
				2: rsp_stall <= stall_tick[4];
				default: rsp_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_bins.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: index %0d real %0d imag %0d",
						rsp.out_index, rsp.out_real, rsp.out_imag);
			end else begin
				out_word_t e;
				e = expected_bins.pop_front();
				applies_checked++;
				if (e.out_index !== rsp.out_index || e.out_real !== rsp.out_real ||
						e.out_imag !== rsp.out_imag) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp idx %0d re %0d im %0d, got idx %0d re %0d im %0d",
							e.out_index, e.out_real, e.out_imag,
							rsp.out_index, rsp.out_real, rsp.out_imag);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [15:0] strength_set[6] = '{16'd4096, 16'd0, 16'hFFFF, 16'd8192, 16'd2048, 16'd6000};
		logic [15:0] floor_set[6]    = '{16'd0, 16'hFFFF, 16'd0, 16'd410, 16'd2048, 16'd8000};
		cycles = 0;
		mismatches = 0;
		applies_checked = 0;
		frame_count = 0;
		strength = STRENGTH_RST;
		floor_gain = FLOOR_RST;
		foreach (noise_sum[i])
			noise_sum[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: first frame writes every used bin with extreme and small parts
		queue_word(OP_APPLY, 5, 24'h123456, 24'hFEDCBA, 1'b0);   // no profile
		queue_word(OP_CAPTURE, 0, 24'h800000, 24'h800000, 1'b0);
		queue_word(OP_CAPTURE, 1, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
		queue_word(OP_CAPTURE, 2, 24'd0, 24'd0, 1'b0);
		queue_word(OP_CAPTURE, 3, 24'd300, 24'hFFFFFC, 1'b0);
		queue_word(OP_CAPTURE, 255, 24'd3000, 24'd4000, 1'b0);
		queue_word(OP_CAPTURE, 511, 24'hFF0000, 24'd5, 1'b0);
		queue_word(OP_CAPTURE, 512, 24'd20, 24'd0, 1'b1);
		queue_word(OP_APPLY, 0, 24'd0, 24'd0, 1'b0);               // zero magnitude
		queue_word(OP_APPLY, 1, 24'h7FFFFF, 24'h800000, 1'b1);
		queue_word(OP_APPLY, 3, 24'd100, 24'd0, 1'b0);            // subtracted to zero
		queue_word(OP_APPLY, 255, 24'd6000, 24'hFFE0C0, 1'b0);
		queue_word(OP_APPLY, 512, 24'd30, 24'd40, 1'b0);
		queue_word(OP_APPLY, 1023, 24'h7FFFFF, 24'h800000, 1'b0); // out of range
		queue_word(OP_CAPTURE, 700, 24'd55, 24'd66, 1'b1);        // frame end, no store
		queue_word(OP_NONE, 10'h2AA, 24'h555555, 24'hAAAAAA, 1'b1);
		queue_word(OP_APPLY, 2, 24'd1, 24'd0, 1'b0);
		queue_word(OP_CLEAR, 0, 24'd0, 24'd0, 1'b0);
		queue_word(OP_APPLY, 255, 24'd6000, 24'd100, 1'b0);       // profile cleared
		queue_word(OP_CAPTURE, 255, 24'd10, 24'd0, 1'b1);         // overwrite after clear
		queue_word(OP_APPLY, 255, 24'd50, 24'hFFFFF0, 1'b0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_STRENGTH, strength_set[p]);
			write_reg(REG_FLOOR, floor_set[p]);
			queue_random(30);
			if (p == 3) begin
				// saturate the frame count, then check captures are ignored
				for (int i = 0; i < 260; i++)
					queue_word(OP_CAPTURE, $urandom_range(NBINS, 1023), rand_part(), rand_part(), 1'b1);
				queue_frame();
				for (int i = 0; i < 7; i++)
					queue_word(OP_APPLY, used_bins[i], rand_part(), rand_part(), 1'b0);
				queue_word(OP_CLEAR, 0, 24'd0, 24'd0, 1'b0);
				queue_frame();
			end
			wait_idle();
		end

		$display("Checked %0d applied bins over 6 strength/floor settings,", applies_checked);
		$display("with capture, clear, unused opcode and frame count saturation traffic.");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
